// ===== design/rspe_pkg.sv =====
package rspe_pkg;

    localparam int NUM_PARITY = 13;
    localparam int IDX_W = $clog2(NUM_PARITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARITY - 1);
    localparam logic [7:0] GF_REDUCE = 8'h1D;

    // generator alpha exponents, highest degree first
    localparam logic [7:0] GEN_EXP [NUM_PARITY+1] = '{
        8'd0, 8'd74, 8'd152, 8'd176, 8'd100, 8'd86, 8'd100,
        8'd106, 8'd104, 8'd130, 8'd218, 8'd206, 8'd140, 8'd78
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       last_parity;
    } out_item_t;

    typedef logic [NUM_PARITY-1:0][7:0] block_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_status_t;

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        logic [7:0] r;
        r = {a[6:0], 1'b0};
        if (a[7])
        begin
            r = r ^ GF_REDUCE;
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x;
            end
            x = gf_double(x);
        end
        return acc;
    endfunction

    // elaboration only: constant exponent
    function automatic logic [7:0] gf_alpha_pow(input logic [7:0] e);
        logic [7:0] r;
        r = 8'h01;
        for (int k = 0; k < 256; k++)
        begin
            if (k < int'(e))
            begin
                r = gf_double(r);
            end
        end
        return r;
    endfunction

endpackage

// ===== design/rspe_front.sv =====
module rspe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               data_valid,
    output logic               data_stall,
    input  rspe_pkg::in_item_t data,
    input  rspe_pkg::q_status_t q_status,
    output logic               push,
    output rspe_pkg::block_t   push_block
);

    logic [7:0] rem_reg  [rspe_pkg::NUM_PARITY];
    logic [7:0] rem_next [rspe_pkg::NUM_PARITY];
    logic [7:0] prod     [rspe_pkg::NUM_PARITY];
    logic [7:0] fb;
    logic       accept;

    assign data_stall = q_status.full;
    assign accept     = data_valid && !data_stall;
    assign fb         = data.data_byte ^ rem_reg[0];

    // constant multipliers of the generator
    for (genvar g = 0; g < rspe_pkg::NUM_PARITY; g++)
    begin : g_coef
        localparam logic [7:0] COEF = rspe_pkg::gf_alpha_pow(rspe_pkg::GEN_EXP[g+1]);
        assign prod[g] = rspe_pkg::gf_mul(fb, COEF);
    end

    always_comb
    begin
        for (int i = 0; i < rspe_pkg::NUM_PARITY - 1; i++)
        begin
            rem_next[i] = rem_reg[i+1] ^ prod[i];
        end
        rem_next[rspe_pkg::NUM_PARITY-1] = prod[rspe_pkg::NUM_PARITY-1];
    end

    always_comb
    begin
        for (int i = 0; i < rspe_pkg::NUM_PARITY; i++)
        begin
            push_block[i] = rem_next[i];
        end
    end

    assign push = accept && data.last_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rspe_pkg::NUM_PARITY; i++)
            begin
                rem_reg[i] <= 8'h00;
            end
        end
        else if (accept)
        begin
            for (int i = 0; i < rspe_pkg::NUM_PARITY; i++)
            begin
                rem_reg[i] <= data.last_data ? 8'h00 : rem_next[i];
            end
        end
    end

endmodule

// ===== design/rspe_queue.sv =====
module rspe_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rspe_pkg::block_t    push_block,
    input  logic                pop,
    output rspe_pkg::block_t    pop_block,
    output rspe_pkg::q_status_t q_status
);

    localparam int DEPTH = 2;

    rspe_pkg::block_t entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_status.full  = (count_reg == 2'(DEPTH));
    assign q_status.avail = (count_reg != 2'd0);
    assign pop_block      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_block;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_status.full || pop))
        else $error("block pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_status.avail)
        else $error("block popped from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ===== design/rspe_back.sv =====
module rspe_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  rspe_pkg::q_status_t q_status,
    input  rspe_pkg::block_t    pop_block,
    output logic                pop,
    output logic                parity_valid,
    input  logic                parity_stall,
    output rspe_pkg::out_item_t parity
);

    rspe_pkg::block_t              shift_reg;
    rspe_pkg::block_t              shift_next;
    logic [rspe_pkg::IDX_W-1:0]    idx_reg;
    logic [rspe_pkg::IDX_W-1:0]    idx_next;
    logic                          busy_reg;
    logic                          busy_next;
    logic                          valid_reg;
    logic                          valid_next;
    rspe_pkg::out_item_t           out_reg;
    rspe_pkg::out_item_t           out_next;
    logic                          load_out;
    logic                          sending;
    logic                          finishing;

    assign load_out  = !valid_reg || !parity_stall;
    assign sending   = busy_reg && load_out;
    assign finishing = sending && (idx_reg == rspe_pkg::LAST_IDX);
    assign pop       = q_status.avail && (!busy_reg || finishing);

    always_comb
    begin
        shift_next = shift_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (load_out)
        begin
            valid_next = busy_reg;
        end
        if (sending)
        begin
            out_next.parity_byte = shift_reg[0];
            out_next.last_parity = (idx_reg == rspe_pkg::LAST_IDX);
            shift_next = {8'h00, shift_reg[rspe_pkg::NUM_PARITY-1:1]};
            idx_next   = idx_reg + rspe_pkg::IDX_W'(1);
        end
        if (finishing)
        begin
            busy_next = 1'b0;
            idx_next  = '0;
        end
        if (pop)
        begin
            shift_next = pop_block;
            idx_next   = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    assign parity_valid = valid_reg;
    assign parity       = out_reg;

`ifndef SYNTHESIS
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (idx_reg == '0))
        else $error("byte index not cleared while idle");

    a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_reg.last_parity && !parity_stall)
        |=> !(valid_reg && out_reg.last_parity))
        else $error("two final parity bytes in a row");
`endif

endmodule

// ===== design/reed_solomon_parity_encoder.sv =====
// latency: the last message byte's parity block passes through the block queue, the serializer and the output register
// throughput: one message byte per cycle in while the queue is not full; one parity byte per cycle out while
// parity_stall is low, 13 per message; the input stalls while two parity blocks wait for the serializer
// reset: asynchronous, active low; clears the remainder, the queue count and pointers and the output valid
module reed_solomon_parity_encoder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    output logic                data_stall,
    input  rspe_pkg::in_item_t  data,
    output logic                parity_valid,
    input  logic                parity_stall,
    output rspe_pkg::out_item_t parity
);

    rspe_pkg::q_status_t q_status;
    rspe_pkg::block_t    push_block;
    rspe_pkg::block_t    pop_block;
    logic                push;
    logic                pop;

    rspe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data       (data),
        .q_status   (q_status),
        .push       (push),
        .push_block (push_block)
    );

    rspe_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_block (push_block),
        .pop        (pop),
        .pop_block  (pop_block),
        .q_status   (q_status)
    );

    rspe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .pop_block    (pop_block),
        .pop          (pop),
        .parity_valid (parity_valid),
        .parity_stall (parity_stall),
        .parity       (parity)
    );

endmodule
